[rtl/tac_pkg.sv]
`default_nettype none

package tac_pkg;

    localparam int unsigned TIME_W     = 48;
    localparam int unsigned SPACING_W  = 16;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned ERRCNT_W   = 16;
    localparam int unsigned SPEED_W    = 22;
    localparam int unsigned MOVED_W    = 2;
    localparam int unsigned DIV_STEPS  = SPEED_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 80;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd1850;
    localparam logic [ERRCNT_W-1:0]  ERRCNT_MAX    = 16'hFFFF;

    typedef logic [3:0] t_track_st;
    typedef logic [2:0] t_cmd;
    typedef logic [MOVED_W-1:0] t_moved;

    localparam t_track_st TS_START = 4'd0;
    localparam t_track_st TS_FREE  = 4'd1;
    localparam t_track_st TS_E10   = 4'd2;
    localparam t_track_st TS_E1011 = 4'd3;
    localparam t_track_st TS_L01   = 4'd4;
    localparam t_track_st TS_E01   = 4'd5;
    localparam t_track_st TS_E0111 = 4'd6;
    localparam t_track_st TS_L10   = 4'd7;
    localparam t_track_st TS_E11   = 4'd8;

    localparam t_cmd CMD_NONE   = 3'd0;
    localparam t_cmd CMD_INC    = 3'd1;
    localparam t_cmd CMD_DEC    = 3'd2;
    localparam t_cmd CMD_INC_G  = 3'd3;
    localparam t_cmd CMD_DEC_G  = 3'd4;
    localparam t_cmd CMD_LAST_G = 3'd5;

    localparam t_moved MOVED_NONE = 2'd0;
    localparam t_moved MOVED_FWD  = 2'd1;
    localparam t_moved MOVED_BACK = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [SPEED_W-1:0]    dividend;
        logic [TIME_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [SPEED_W-1:0]    quotient;
    } t_div_rsp;

    // occ = {occ0, occ1}, 1 = occupied
    function automatic t_track_st next_state(input t_track_st cur, input logic [1:0] occ);
        t_track_st nxt;
        nxt = TS_START;
        if (occ == 2'b00) begin
            nxt = TS_FREE;
        end else begin
            case (cur)
                TS_FREE: begin
                    case (occ)
                        2'b01:   nxt = TS_E01;
                        2'b10:   nxt = TS_E10;
                        default: nxt = TS_E11;
                    endcase
                end
                TS_E10, TS_E1011, TS_L01: begin
                    case (occ)
                        2'b01:   nxt = TS_L01;
                        2'b10:   nxt = TS_E10;
                        default: nxt = TS_E1011;
                    endcase
                end
                TS_E01, TS_E0111, TS_L10: begin
                    case (occ)
                        2'b01:   nxt = TS_E01;
                        2'b10:   nxt = TS_L10;
                        default: nxt = TS_E0111;
                    endcase
                end
                TS_E11: begin
                    case (occ)
                        2'b01:   nxt = TS_L01;
                        2'b10:   nxt = TS_L10;
                        default: nxt = TS_E11;
                    endcase
                end
                default: nxt = TS_START;
            endcase
        end
        return nxt;
    endfunction

    function automatic t_cmd exit_cmd(input t_track_st cur);
        t_cmd c;
        case (cur)
            TS_E1011: c = CMD_INC_G;
            TS_L01:   c = CMD_INC;
            TS_E0111: c = CMD_DEC_G;
            TS_L10:   c = CMD_DEC;
            TS_E11:   c = CMD_LAST_G;
            default:  c = CMD_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/tac_div.sv]
`default_nettype none

module tac_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire tac_pkg::t_div_req i_req,
    output tac_pkg::t_div_rsp    o_rsp
);
    import tac_pkg::*;

    logic                   r_busy;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [SPEED_W-1:0]     r_quo;
    logic [SPEED_W-1:0]     r_rem;
    logic [TIME_W-1:0]      r_dvs;
    logic                   r_done;

    logic [SPEED_W:0]       trial;
    logic                   ge;
    logic [SPEED_W:0]       diff;

    assign trial = {r_rem, r_quo[SPEED_W-1]};
    assign ge    = {{(TIME_W-SPEED_W-1){1'b0}}, trial} >= r_dvs;
    assign diff  = trial - r_dvs[SPEED_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SPEED_W-2:0], ge};
            r_rem <= ge ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

[rtl/two_sensor_axle_counter.sv]
`default_nettype none

// Two-sensor axle counter. Each input beat carries the two active-low sensor
// bits, an inhibit flag and a millisecond timestamp; each one yields exactly
// one output beat with the running axle count, direction, glitch flag and
// count, speed (km/h x10) and the count event of that tick. When the speed
// is recomputed, the 22-bit quotient comes from a restoring divider that
// produces one bit per cycle, and the output register is loaded once it is
// done. A new beat can be taken as soon as the result has been loaded into
// the output register. The input is not ready while a beat is in work; a
// finished result waits in the output register while the next beat is taken,
// and a result that finds the output register still full holds the block
// until it frees. The axle spacing register is written through i_cfg_wr_en /
// i_cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module two_sensor_axle_counter (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wr_en,
    input  wire [tac_pkg::SPACING_W-1:0]    i_cfg_wr_data,
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [0] b0_raw, [1] b1_raw, [2] inhibit, [50:3] time_ms, [55:51] zero
    input  wire [tac_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // [31:0] axle_count, [32] direction, [33] error_track,
    // [49:34] error_count, [71:50] speed_x10, [73:72] moved, [79:74] zero
    output logic [tac_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import tac_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]             r_state, n_state;

    logic [1:0]             r_occ;
    logic                   r_inhibit;
    logic [TIME_W-1:0]      r_time;

    logic [SPACING_W-1:0]   r_spacing;
    t_track_st              r_track, n_track;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic                   r_dir, n_dir;
    logic                   r_err_flag, n_err_flag;
    logic [ERRCNT_W-1:0]    r_err_cnt, n_err_cnt;
    logic [SPEED_W-1:0]     r_speed, n_speed;
    logic                   r_last_valid, n_last_valid;
    logic                   r_last_dir, n_last_dir;
    logic [TIME_W-1:0]      r_last_time, n_last_time;
    t_moved                 r_moved, n_moved;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    t_track_st              cur;
    t_track_st              nxt;
    t_cmd                   cmd;
    logic                   back;
    logic                   glitch;
    logic [TIME_W:0]        dt;
    logic                   time_adv;
    logic                   in_acc;
    logic                   out_load;
    t_div_req               div_req;
    t_div_rsp               div_rsp;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    assign cur      = (r_track > TS_E11) ? TS_START : r_track;
    assign nxt      = next_state(cur, r_occ);
    assign cmd      = exit_cmd(cur);
    assign back     = (cmd == CMD_DEC) || (cmd == CMD_DEC_G)
                   || ((cmd == CMD_LAST_G) && r_dir);
    assign glitch   = (cmd == CMD_INC_G) || (cmd == CMD_DEC_G) || (cmd == CMD_LAST_G);
    assign dt       = {1'b0, r_time} - {1'b0, r_last_time};
    assign time_adv = !dt[TIME_W] && (dt[TIME_W-1:0] != '0);

    always_comb begin
        n_state      = r_state;
        n_track      = r_track;
        n_count      = r_count;
        n_dir        = r_dir;
        n_err_flag   = r_err_flag;
        n_err_cnt    = r_err_cnt;
        n_speed      = r_speed;
        n_last_valid = r_last_valid;
        n_last_dir   = r_last_dir;
        n_last_time  = r_last_time;
        n_moved      = r_moved;
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, r_spacing, 5'b0} + {4'b0, r_spacing, 2'b0};
        div_req.divisor  = dt[TIME_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_moved = MOVED_NONE;
                n_state = S_DONE;
                if (!r_inhibit) begin
                    n_track = nxt;
                    if ((nxt != cur) && (nxt == TS_FREE) && (cmd != CMD_NONE)) begin
                        n_count      = back ? r_count - 1'b1 : r_count + 1'b1;
                        n_dir        = back;
                        n_moved      = back ? MOVED_BACK : MOVED_FWD;
                        n_err_flag   = glitch;
                        if (glitch && (r_err_cnt != ERRCNT_MAX)) begin
                            n_err_cnt = r_err_cnt + 1'b1;
                        end
                        n_speed      = '0;
                        n_last_valid = 1'b1;
                        n_last_dir   = back;
                        n_last_time  = r_time;
                        if (r_last_valid && (r_last_dir == back) && !n_count[0]
                                && time_adv) begin
                            div_req.start = 1'b1;
                            n_state       = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_speed = div_rsp.quotient;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_spacing    <= SPACING_RESET;
            r_track      <= TS_START;
            r_count      <= '0;
            r_dir        <= 1'b0;
            r_err_flag   <= 1'b0;
            r_err_cnt    <= '0;
            r_speed      <= '0;
            r_last_valid <= 1'b0;
            r_last_dir   <= 1'b0;
            r_last_time  <= '0;
            r_moved      <= MOVED_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_track      <= n_track;
            r_count      <= n_count;
            r_dir        <= n_dir;
            r_err_flag   <= n_err_flag;
            r_err_cnt    <= n_err_cnt;
            r_speed      <= n_speed;
            r_last_valid <= n_last_valid;
            r_last_dir   <= n_last_dir;
            r_last_time  <= n_last_time;
            r_moved      <= n_moved;
            if (i_cfg_wr_en) begin
                r_spacing <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_occ     <= {~i_s_axis_tdata[0], ~i_s_axis_tdata[1]};
            r_inhibit <= i_s_axis_tdata[2];
            r_time    <= i_s_axis_tdata[TIME_W+2:3];
        end
        if (out_load) begin
            r_out_data <= {6'b0, r_moved, r_speed, r_err_cnt, r_err_flag, r_dir, r_count};
        end
    end

    tac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[rtl/tac_chk.sv]
`default_nettype none

module tac_chk (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_axis_tvalid,
    input  wire                             o_s_axis_tready,
    input  wire                             o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    input  wire [tac_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import tac_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready while a beat is in work");

    a_moved_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[73:72] == MOVED_NONE)
            || ((o_m_axis_tdata[73:72] == MOVED_FWD) && !o_m_axis_tdata[32])
            || ((o_m_axis_tdata[73:72] == MOVED_BACK) && o_m_axis_tdata[32]))
        else $error("count event disagrees with direction");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("outputs not quiet after reset");

endmodule

bind two_sensor_axle_counter tac_chk u_tac_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
